@@ hdl/breakpoint_address_table_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Breakpoint address table assertion macros
// Shorthand for clocked assertions, with reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_ADDRESS_TABLE_UNIT_ASSERT_SVH
`define BREAKPOINT_ADDRESS_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds in the same cycle.
`define BATU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons holds in the next cycle.
`define BATU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/batu_pkg.sv @@
// ----------------------------------------------------------------------------
// batu_pkg
// Shared types and constants of the breakpoint address table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package batu_pkg;

	localparam int ENTRIES       = 16;
	localparam int ADDR_W        = 32;
	localparam int COUNT_W       = $clog2(ENTRIES + 1);
	localparam int ENTRY_COUNT_W = 5;
	localparam int DATA_W        = 32;
	localparam int CFG_IDX_W     = 1;
	localparam int PADDR_W       = CFG_IDX_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_MEM_LIMIT = 1'b0;
	localparam logic [ADDR_W-1:0]    MEM_LIMIT_RST = '1;

	typedef enum logic [1:0] {
		FN_CHECK  = 2'd0,
		FN_ADD    = 2'd1,
		FN_REMOVE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Operation token that walks down the cell row.
	typedef struct packed {
		logic              vld;
		func_t             func;
		logic [ADDR_W-1:0] addr;
		logic              addr_ok;  // add: address below the limit
		logic              flag;     // hit / slot taken / entry removed
	} tok_t;

	// One table entry, as seen by the neighboring cell.
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr;
	} entry_t;

	typedef struct packed {
		logic                     hit;
		status_t                  status;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} res_t;

endpackage

`default_nettype wire

@@ hdl/batu_cell.sv @@
// ----------------------------------------------------------------------------
// batu_cell
// One table slot: holds an entry and applies the passing operation token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module batu_cell (
	input  wire                clk,
	input  wire                arst_n,
	input  batu_pkg::tok_t     tok_in,
	input  batu_pkg::entry_t   nbr,
	output batu_pkg::tok_t     tok_out,
	output batu_pkg::entry_t   ent
);

	logic                        valid_q;
	logic [batu_pkg::ADDR_W-1:0] addr_q;
	logic                        tok_vld_q;
	batu_pkg::tok_t              tok_q;
	batu_pkg::tok_t              tok_nxt;

	logic match;
	logic wr;
	logic shift;
	logic clr;
	logic flag_nxt;

	assign match = valid_q && (addr_q == tok_in.addr);

	always_comb begin
		wr       = 1'b0;
		shift    = 1'b0;
		clr      = 1'b0;
		flag_nxt = tok_in.flag;
		case (tok_in.func)
			batu_pkg::FN_CHECK: begin
				flag_nxt = tok_in.flag || match;
			end
			batu_pkg::FN_ADD: begin
				wr       = tok_in.addr_ok && !tok_in.flag && !valid_q;
				flag_nxt = tok_in.flag || wr;
			end
			batu_pkg::FN_REMOVE: begin
				// pull the neighbor down from the matching slot onward
				shift    = tok_in.flag || match;
				flag_nxt = shift;
			end
			batu_pkg::FN_CLEAR: begin
				clr = 1'b1;
			end
			default: begin
				flag_nxt = tok_in.flag;
			end
		endcase
	end

	always_comb begin
		tok_nxt      = tok_in;
		tok_nxt.flag = flag_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
			if (tok_in.vld) begin
				if (clr) begin
					valid_q <= 1'b0;
				end else if (shift) begin
					valid_q <= nbr.valid;
				end else if (wr) begin
					valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			if (shift) begin
				addr_q <= nbr.addr;
			end else if (wr) begin
				addr_q <= tok_in.addr;
			end
		end
		tok_q <= tok_nxt;
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = tok_vld_q;
	end

	assign ent.valid = valid_q;
	assign ent.addr  = addr_q;

endmodule

`default_nettype wire

@@ hdl/breakpoint_address_table_unit.sv @@
// ----------------------------------------------------------------------------
// breakpoint_address_table_unit
// Packed table of debug breakpoint addresses built as a row of slot cells.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                               Direction  Transfer when
//   input     in_valid in_ready func addr           into unit  in_valid & in_ready
//   output    out_valid out_ready hit status        out of     out_valid & out_ready
//             entry_count
//   config    psel penable pwrite paddr pwdata      APB        psel & penable & pwrite
//             prdata pready
//
// An operation token enters slot 0 at the input transfer and moves one slot per
// cycle; the result is formed as it leaves the last cell of the row and is
// registered into the output buffer. One operation is in flight at a time, so
// no new input is taken until the current token has left the row.
// A finished result waits in a two-deep output buffer; the input stays open while
// one result waits and closes while two do.
// Reset clears all slot valid bits, the count and the output buffer at once;
// no clearing pass is needed and mem_limit returns to all ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module breakpoint_address_table_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// operation input
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [1:0]                           func,
	input  wire  [batu_pkg::ADDR_W-1:0]          addr,
	// result output
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 hit,
	output logic [1:0]                           status,
	output logic [batu_pkg::ENTRY_COUNT_W-1:0]   entry_count,
	// configuration port
	input  wire                                  psel,
	input  wire                                  penable,
	input  wire                                  pwrite,
	input  wire  [batu_pkg::PADDR_W-1:0]         paddr,
	input  wire  [batu_pkg::DATA_W-1:0]          pwdata,
	output logic [batu_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [batu_pkg::ADDR_W-1:0]    mem_limit_q;
	logic [batu_pkg::CFG_IDX_W-1:0] cfg_idx;

	assign cfg_idx = paddr[batu_pkg::PADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_limit_q <= batu_pkg::MEM_LIMIT_RST;
		end else if (psel && penable && pwrite && (cfg_idx == batu_pkg::REG_MEM_LIMIT)) begin
			mem_limit_q <= pwdata;
		end
	end

	always_comb begin
		prdata = '0;
		if (cfg_idx == batu_pkg::REG_MEM_LIMIT) begin
			prdata = mem_limit_q;
		end
	end

	// ------------------------------------------------------------------
	// Cell row: tok[i] enters cell i, tok[ENTRIES] leaves the last cell
	// ------------------------------------------------------------------
	batu_pkg::tok_t   tok [0:batu_pkg::ENTRIES];
	batu_pkg::entry_t ent [0:batu_pkg::ENTRIES-1];
	batu_pkg::tok_t   exit_tok;

	logic busy_q;
	logic hold_valid_q;
	logic accept;

	assign in_ready = !busy_q && !hold_valid_q;
	assign accept   = in_valid && in_ready;

	// Build the entering token; the limit compare is done once, here.
	always_comb begin
		tok[0].vld     = accept;
		tok[0].func    = batu_pkg::func_t'(func);
		tok[0].addr    = addr;
		tok[0].addr_ok = (addr < mem_limit_q);
		tok[0].flag    = 1'b0;
	end

	for (genvar i = 0; i < batu_pkg::ENTRIES; i++) begin : g_cell
		batu_pkg::entry_t nbr;

		// The last slot sees an empty neighbor, so a shift frees it.
		if (i == batu_pkg::ENTRIES - 1) begin : g_last
			assign nbr.valid = 1'b0;
			assign nbr.addr  = ent[i].addr;
		end else begin : g_mid
			assign nbr = ent[i+1];
		end

		batu_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.nbr     (nbr),
			.tok_out (tok[i+1]),
			.ent     (ent[i])
		);
	end

	assign exit_tok = tok[batu_pkg::ENTRIES];

	// ------------------------------------------------------------------
	// Result and entry count, formed as the token leaves the row
	// ------------------------------------------------------------------
	logic [batu_pkg::COUNT_W-1:0] count_q;
	logic [batu_pkg::COUNT_W-1:0] count_nxt;
	batu_pkg::res_t               res;

	always_comb begin
		count_nxt  = count_q;
		res.hit    = 1'b0;
		res.status = batu_pkg::ST_OK;
		case (exit_tok.func)
			batu_pkg::FN_CHECK: begin
				res.hit = exit_tok.flag;
			end
			batu_pkg::FN_ADD: begin
				if (!exit_tok.addr_ok) begin
					res.status = batu_pkg::ST_INVALID;
				end else if (!exit_tok.flag) begin
					res.status = batu_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			batu_pkg::FN_REMOVE: begin
				if (!exit_tok.flag) begin
					res.status = batu_pkg::ST_NOT_FOUND;
				end else begin
					count_nxt = count_q - 1'b1;
				end
			end
			batu_pkg::FN_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				res.status = batu_pkg::ST_OK;
			end
		endcase
		res.entry_count = batu_pkg::ENTRY_COUNT_W'(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (exit_tok.vld) begin
				count_q <= count_nxt;
			end
			// hold off new operations while one walks the row
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exit_tok.vld) begin
				busy_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Two-deep output buffer: out_q drives the ports, hold_q catches a
	// result that leaves the row while out_q is stalled.
	// ------------------------------------------------------------------
	logic           out_valid_q;
	batu_pkg::res_t out_q;
	batu_pkg::res_t hold_q;
	logic           ld_out_exit;
	logic           ld_out_hold;
	logic           ld_hold;

	always_comb begin
		ld_out_exit = 1'b0;
		ld_out_hold = 1'b0;
		ld_hold     = 1'b0;
		if (!out_valid_q || out_ready) begin
			if (hold_valid_q) begin
				ld_out_hold = 1'b1;
			end else begin
				ld_out_exit = exit_tok.vld;
			end
		end else begin
			ld_hold = exit_tok.vld;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_ready) begin
				out_valid_q <= ld_out_hold || ld_out_exit;
			end
			if (ld_hold) begin
				hold_valid_q <= 1'b1;
			end else if (ld_out_hold) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out_hold) begin
			out_q <= hold_q;
		end else if (ld_out_exit) begin
			out_q <= res;
		end
		if (ld_hold) begin
			hold_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = out_q.hit;
	assign status      = out_q.status;
	assign entry_count = out_q.entry_count;

endmodule

`default_nettype wire

@@ hdl/batu_chk.sv @@
// ----------------------------------------------------------------------------
// batu_chk
// Port-level checks of the breakpoint address table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "breakpoint_address_table_unit_assert.svh"

module batu_chk (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 in_valid,
	input wire                                 in_ready,
	input wire                                 out_valid,
	input wire                                 out_ready,
	input wire                                 hit,
	input wire [1:0]                           status,
	input wire [batu_pkg::ENTRY_COUNT_W-1:0]   entry_count
);

	logic                               in_xfer;
	logic                               out_stall;
	logic                               full_rsp;
	logic                               at_cap;
	logic [batu_pkg::ENTRY_COUNT_W+2:0] out_word;

	assign in_xfer   = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;
	assign full_rsp  = out_valid && (status == batu_pkg::ST_FULL);
	assign at_cap    = (entry_count == batu_pkg::ENTRY_COUNT_W'(batu_pkg::ENTRIES));
	assign out_word  = {hit, status, entry_count};

	// a transfer in closes the input until that operation has walked the row
	`BATU_ASSERT_NEXT(a_one_in_flight, in_xfer, !in_ready, "operation taken while one is in flight")

	// a hit only comes with an ok status
	`BATU_ASSERT_SAME(a_hit_ok, out_valid && hit, status == batu_pkg::ST_OK, "hit with failing status")

	// table full is only reported when every slot is held
	`BATU_ASSERT_SAME(a_full_count, full_rsp, at_cap, "table full reported below capacity")

	// a stalled result holds
	`BATU_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind breakpoint_address_table_unit batu_chk u_batu_chk (.*);

`default_nettype wire
